@@ design/work_stealing_deque_macros.svh @@
// Assertion helpers used by the checker file
`ifndef WORK_STEALING_DEQUE_MACROS_SVH
`define WORK_STEALING_DEQUE_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define WSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("deque check failed");

// Condition must never be seen outside reset
`define WSD_ASSERT_NEVER(label, clk, rst_n, cond) \
  `WSD_ASSERT(label, clk, rst_n, !(cond))

`endif

@@ design/wsd_pkg.sv @@
`timescale 1ns / 1ps

package wsd_pkg;

  // Slot store geometry; indices carry one extra lap bit
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned SLOT_W   = $clog2(CAPACITY);
  localparam int unsigned PTR_W    = SLOT_W + 1;
  localparam int unsigned HANDLE_W = 64;
  localparam int unsigned OCC_W    = 9;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_STEAL = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } fsm_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [HANDLE_W-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] item_value;
    logic [1:0]          status;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

@@ design/wsd_datapath.sv @@
`timescale 1ns / 1ps

module wsd_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wsd_pkg::ctrl_t ctrl_i,
  input  wsd_pkg::req_t  req_i,
  output wsd_pkg::res_t  res_o
);

  logic [1:0]                   op_q;
  logic [wsd_pkg::HANDLE_W-1:0] val_q;
  logic [wsd_pkg::PTR_W-1:0]    top_q, top_d;
  logic [wsd_pkg::PTR_W-1:0]    bot_q, bot_d;
  logic [wsd_pkg::PTR_W-1:0]    held;
  logic [wsd_pkg::PTR_W-1:0]    held_d;
  logic [wsd_pkg::SLOT_W-1:0]   waddr, raddr;
  logic                         we, take_d, take_q;
  logic [1:0]                   status_d, status_q;
  logic [wsd_pkg::OCC_W-1:0]    occ_q;
  logic [wsd_pkg::HANDLE_W-1:0] rd_q;
  logic [wsd_pkg::HANDLE_W-1:0] mem [wsd_pkg::CAPACITY];
  logic                         is_full, is_empty;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= req_i.opcode;
      val_q <= req_i.push_value;
    end
  end

  // Occupancy from the lapped indices
  assign held     = bot_q - top_q;
  assign is_full  = (held == wsd_pkg::PTR_W'(wsd_pkg::CAPACITY));
  assign is_empty = (held == '0);

  // Pointer update and slot addressing
  always_comb begin
    top_d    = top_q;
    bot_d    = bot_q;
    we       = 1'b0;
    take_d   = 1'b0;
    status_d = wsd_pkg::ST_DONE;
    held_d   = held;
    waddr    = bot_q[wsd_pkg::SLOT_W-1:0];
    raddr    = top_q[wsd_pkg::SLOT_W-1:0];
    case (op_q)
      wsd_pkg::OP_PUSH: begin
        if (is_full) begin
          status_d = wsd_pkg::ST_FULL;
        end else begin
          we     = 1'b1;
          bot_d  = bot_q + 1'b1;
          held_d = held + 1'b1;
        end
      end
      wsd_pkg::OP_POP: begin
        raddr = wsd_pkg::SLOT_W'(bot_q - 1'b1);
        if (is_empty) begin
          status_d = wsd_pkg::ST_EMPTY;
        end else begin
          take_d = 1'b1;
          bot_d  = bot_q - 1'b1;
          held_d = held - 1'b1;
        end
      end
      wsd_pkg::OP_STEAL: begin
        if (is_empty) begin
          status_d = wsd_pkg::ST_EMPTY;
        end else begin
          take_d = 1'b1;
          top_d  = top_q + 1'b1;
          held_d = held - 1'b1;
        end
      end
      default: begin
        // unused opcode: no change
      end
    endcase
  end

  // Index registers and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      bot_q  <= '0;
      take_q <= 1'b0;
    end else if (ctrl_i.exec) begin
      top_q  <= top_d;
      bot_q  <= bot_d;
      take_q <= take_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      status_q <= status_d;
      occ_q    <= wsd_pkg::OCC_W'(held_d);
    end
  end

  // Slot store, registered read
  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && we) begin
      mem[waddr] <= val_q;
    end
    if (ctrl_i.exec) begin
      rd_q <= mem[raddr];
    end
  end

  assign res_o.item_value = take_q ? rd_q : '0;
  assign res_o.status     = status_q;
  assign res_o.occupancy  = occ_q;

endmodule

@@ design/wsd_ctrl.sv @@
`timescale 1ns / 1ps

module wsd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           valid_o,
  output wsd_pkg::ctrl_t ctrl_o
);

  wsd_pkg::fsm_e state_q, state_d;
  logic          accept;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands; a new request may enter while the result shows
  always_comb begin
    busy_o      = 1'b0;
    valid_o     = 1'b0;
    state_d     = state_q;
    accept      = 1'b0;
    ctrl_o.exec = 1'b0;
    case (state_q)
      wsd_pkg::S_IDLE: begin
        accept = start_i;
        if (accept) begin
          state_d = wsd_pkg::S_EXEC;
        end
      end
      wsd_pkg::S_EXEC: begin
        busy_o      = 1'b1;
        ctrl_o.exec = 1'b1;
        state_d     = wsd_pkg::S_RESP;
      end
      wsd_pkg::S_RESP: begin
        valid_o = 1'b1;
        accept  = start_i;
        state_d = accept ? wsd_pkg::S_EXEC : wsd_pkg::S_IDLE;
      end
      default: begin
        state_d = wsd_pkg::S_IDLE;
      end
    endcase
    ctrl_o.load = accept;
  end

endmodule

@@ design/work_stealing_deque.sv @@
`timescale 1ns / 1ps

// Work-stealing deque of 256 64-bit task handles. A request (push at the
// bottom, pop from the bottom, steal from the top) is taken when start is high
// and busy is low. Its result shows on res_o with valid_o high for exactly one
// cycle, in the result state that follows the execute state, and the receiver
// cannot hold it off. Busy is high only in the execute state, so a new request
// can be taken in the same cycle its predecessor's result is shown; none is
// taken while busy. The execute state updates the indices and does the
// registered read of the slot memory. A full push reports full, a pop or steal
// on an empty deque reports empty; both return a zero handle and leave the
// deque as it was.
// Reset clears the indices at once; no clearing pass is run.
module work_stealing_deque (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  wsd_pkg::req_t req_i,
  output logic          valid_o,
  output wsd_pkg::res_t res_o
);

  wsd_pkg::ctrl_t ctrl;

  // Sequencer
  wsd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .valid_o (valid_o),
    .ctrl_o  (ctrl)
  );

  // Indices and slot store
  wsd_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (req_i),
    .res_o  (res_o)
  );

endmodule

@@ design/wsd_checker.sv @@
`timescale 1ns / 1ps
`include "work_stealing_deque_macros.svh"

module wsd_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          valid_o,
  input wsd_pkg::res_t res_o
);

  // A taken request leads to busy, and busy to a shown result with busy low
  `WSD_ASSERT(a_req_to_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `WSD_ASSERT(a_busy_to_res, clk_i, rst_ni, busy |=> (valid_o && !busy))
  // Result never shows while busy
  `WSD_ASSERT_NEVER(a_res_busy, clk_i, rst_ni, valid_o && busy)
  // Refused or empty requests return no handle
  `WSD_ASSERT(a_fail_zero, clk_i, rst_ni,
    (valid_o && (res_o.status != wsd_pkg::ST_DONE)) |-> (res_o.item_value == '0))
  // Occupancy bounded by capacity
  `WSD_ASSERT(a_occ_bound, clk_i, rst_ni,
    valid_o |-> (res_o.occupancy <= wsd_pkg::OCC_W'(wsd_pkg::CAPACITY)))

endmodule

bind work_stealing_deque wsd_checker u_wsd_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .res_o   (res_o)
);
